/* sv/atib_pkg.sv */
package atib_pkg;

    // Width of the result port.
    localparam int OUT_WIDTH = 32;

    // Radix register: width, value after reset and the largest base honoured.
    localparam int RADIX_W = 5;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

    // Digit value carried between front and back; DIGIT_NONE marks a non-digit.
    localparam int DIGIT_W = 5;
    localparam logic [DIGIT_W-1:0] DIGIT_NONE = 5'd16;

    // Depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // Classified character, as handed from the front to the back.
    typedef struct packed {
        logic                is_space;
        logic                is_plus;
        logic                is_minus;
        logic                is_zero;
        logic                is_x;
        logic [DIGIT_W-1:0]  digit;
        logic                last;
    } char_class_t;

endpackage

/* sv/atib_front.sv */
module atib_front (
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            char_code,
    input  logic                  end_of_string,
    output logic                  push_valid,
    input  logic                  push_ready,
    output atib_pkg::char_class_t push_item
);
    import atib_pkg::*;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_F   = 8'h46;
    localparam logic [7:0] CH_UP_X   = 8'h58;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_F   = 8'h66;
    localparam logic [7:0] CH_LO_X   = 8'h78;
    localparam logic [7:0] TEN       = 8'd10;

    function automatic char_class_t classify(input logic [7:0] c, input logic last);
        char_class_t cls;
        cls.is_space = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
        cls.is_plus  = (c == CH_PLUS);
        cls.is_minus = (c == CH_MINUS);
        cls.is_zero  = (c == CH_ZERO);
        cls.is_x     = (c == CH_LO_X) || (c == CH_UP_X);
        if ((c >= CH_ZERO) && (c <= CH_NINE))
        begin
            cls.digit = DIGIT_W'(c - CH_ZERO);
        end
        else if ((c >= CH_LO_A) && (c <= CH_LO_F))
        begin
            cls.digit = DIGIT_W'(c - CH_LO_A + TEN);
        end
        else if ((c >= CH_UP_A) && (c <= CH_UP_F))
        begin
            cls.digit = DIGIT_W'(c - CH_UP_A + TEN);
        end
        else
        begin
            cls.digit = DIGIT_NONE;
        end
        cls.last = last;
        return cls;
    endfunction

    // Requests go straight into the queue, so the front stalls only when it is full.
    assign in_ready   = push_ready;
    assign push_valid = in_valid;
    assign push_item  = classify(char_code, end_of_string);

endmodule

/* sv/atib_queue.sv */
module atib_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push_valid,
    output logic                  push_ready,
    input  atib_pkg::char_class_t push_item,
    output logic                  pop_valid,
    input  logic                  pop_ready,
    output atib_pkg::char_class_t pop_item
);
    import atib_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    char_class_t            entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg;
    logic [PTR_W-1:0]       rd_ptr_reg;
    logic [CNT_W-1:0]       count_reg;
    logic                   do_push;
    logic                   do_pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                     : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                     : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* sv/atib_back.sv */
module atib_back #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             pop_valid,
    output logic                             pop_ready,
    input  atib_pkg::char_class_t            pop_item,
    input  logic [atib_pkg::RADIX_W-1:0]     radix,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [atib_pkg::OUT_WIDTH-1:0]   parsed_value
);
    import atib_pkg::*;

    typedef enum logic [2:0] {
        PH_WS,
        PH_PRE,
        PH_ZERO,
        PH_DIG,
        PH_STOP
    } phase_t;

    phase_t                     phase_reg,  phase_next;
    logic                       neg_reg,    neg_next;
    logic [VALUE_WIDTH-1:0]     acc_reg,    acc_next;
    logic                       out_valid_reg, out_valid_next;
    logic [OUT_WIDTH-1:0]       value_reg,  value_next;

    logic                       advance;
    logic [RADIX_W-1:0]         radix_eff;
    logic                       digit_ok;
    logic                       prefix_zero;
    logic [VALUE_WIDTH-1:0]     mac;
    logic [VALUE_WIDTH-1:0]     mag;

    assign pop_ready    = !out_valid_reg || out_ready;
    assign advance      = pop_valid && pop_ready;
    assign out_valid    = out_valid_reg;
    assign parsed_value = value_reg;

    assign radix_eff   = (radix > RADIX_MAX) ? RADIX_MAX : radix;
    assign digit_ok    = (pop_item.digit < radix_eff);
    assign prefix_zero = (radix == RADIX_MAX) && pop_item.is_zero;
    assign mac         = VALUE_WIDTH'(acc_reg * VALUE_WIDTH'(radix_eff))
                       + VALUE_WIDTH'(pop_item.digit);

    always_comb
    begin
        phase_next     = phase_reg;
        neg_next       = neg_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg && !out_ready;
        value_next     = value_reg;
        mag            = '0;

        if (advance)
        begin
            unique case (phase_reg)
                PH_WS:
                begin
                    if (pop_item.is_space)
                    begin
                        phase_next = PH_WS;
                    end
                    else if (pop_item.is_plus || pop_item.is_minus)
                    begin
                        neg_next   = pop_item.is_minus;
                        phase_next = PH_PRE;
                    end
                    else if (prefix_zero)
                    begin
                        phase_next = PH_ZERO;
                    end
                    else if (digit_ok)
                    begin
                        acc_next   = mac;
                        phase_next = PH_DIG;
                    end
                    else
                    begin
                        phase_next = PH_STOP;
                    end
                end
                PH_PRE:
                begin
                    if (prefix_zero)
                    begin
                        phase_next = PH_ZERO;
                    end
                    else if (digit_ok)
                    begin
                        acc_next   = mac;
                        phase_next = PH_DIG;
                    end
                    else
                    begin
                        phase_next = PH_STOP;
                    end
                end
                PH_ZERO:
                begin
                    // A leading zero that is not followed by x is simply a digit.
                    if (pop_item.is_x)
                    begin
                        phase_next = PH_DIG;
                    end
                    else if (digit_ok)
                    begin
                        acc_next   = mac;
                        phase_next = PH_DIG;
                    end
                    else
                    begin
                        phase_next = PH_STOP;
                    end
                end
                PH_DIG:
                begin
                    if (digit_ok)
                    begin
                        acc_next   = mac;
                        phase_next = PH_DIG;
                    end
                    else
                    begin
                        phase_next = PH_STOP;
                    end
                end
                PH_STOP:
                begin
                    phase_next = PH_STOP;
                end
                default:
                begin
                    phase_next = PH_STOP;
                end
            endcase

            if (pop_item.last)
            begin
                // The sign is applied to the accumulator as it stands after
                // this character, before the parse state is cleared.
                mag = acc_next;
                if (neg_next)
                begin
                    mag = {VALUE_WIDTH{1'b0}} - acc_next;
                end
                out_valid_next = 1'b1;
                value_next     = OUT_WIDTH'(signed'(mag));
                phase_next     = PH_WS;
                neg_next       = 1'b0;
                acc_next       = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_WS;
            neg_reg       <= 1'b0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
            value_reg     <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            neg_reg       <= neg_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
            value_reg     <= value_next;
        end
    end

endmodule

/* sv/ascii_to_integer_base.sv */
// ascii_to_integer_base: parses a stream of ASCII characters into signed integers.
//
// Input channel (in_valid/in_ready): one request carries one character in
// char_code and end_of_string, which marks the final character of a string.
// Output channel (out_valid/out_ready): one request carries parsed_value, the
// 32-bit signed result, and is produced only for a request with end_of_string.
// Configuration channel (cfg_valid/cfg_ready): one request writes radix, the
// base from 2 to 16; it resets to 10 and is meant to be written while idle.
//
// Throughput is one character per cycle unless the queue is full: a classifier
// front end feeds a two-entry queue, and the back end does the digit multiply-add
// combinationally. A result is registered: its final character passes the queue,
// then the back end's result register. While the receiver stalls, the result
// register holds and the queue absorbs characters; in_ready falls only once the
// queue is full. Reset clears the parse state, the queue and the result register,
// and restores the radix to 10. Overflow wraps at VALUE_WIDTH bits.
module ascii_to_integer_base #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [7:0]                      char_code,
    input  logic                            end_of_string,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [atib_pkg::OUT_WIDTH-1:0]  parsed_value,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [atib_pkg::RADIX_W-1:0]    radix
);
    import atib_pkg::*;

    logic [RADIX_W-1:0] radix_reg;

    logic               push_valid;
    logic               push_ready;
    char_class_t        push_item;
    logic               pop_valid;
    logic               pop_ready;
    char_class_t        pop_item;

    // The radix register is always ready to take a write.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= RADIX_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            radix_reg <= radix;
        end
    end

    atib_front u_front (
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .char_code     (char_code),
        .end_of_string (end_of_string),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_item     (push_item)
    );

    atib_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    atib_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_item     (pop_item),
        .radix        (radix_reg),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .parsed_value (parsed_value)
    );

`ifndef SYNTH
    // A character taken on the input is waiting in the queue on the next cycle.
    a_in_to_queue: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> pop_valid)
        else $error("accepted character did not reach the queue");

    // A result appears only after the back end consumed a final character.
    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(pop_valid && pop_ready && pop_item.last))
        else $error("result produced without a final character");

    // A configuration write lands in the radix register.
    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready) |=> (radix_reg == $past(radix)))
        else $error("radix write lost");
`endif

endmodule
